// ===== rtl/core/stwq_pkg.sv =====
// ============================================================================
// stwq_pkg : shared types and constants of the spoken time word queue
// Defines the command carried from the front end to the sequencer, the word
// codes held in the ring buffer and the payload widths of the stream ports.
// ============================================================================
`default_nettype none

package stwq_pkg;

   // Stream payload widths in bits.
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_TUSER_W = 2;

   // Field widths.
   localparam int FUNC_W    = 2;
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int WORD_W    = 3;
   localparam int NUMBER_W  = 6;
   localparam int DROPPED_W = 3;
   localparam int SLOT_W    = 3;

   // Function codes on the request tuser.
   localparam logic [FUNC_W-1:0] FUNC_SAY_TIME  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PLAY_DONE = 2'd1;

   // Word codes.
   localparam logic [WORD_W-1:0] TOKEN_ITIS    = 3'd0;
   localparam logic [WORD_W-1:0] TOKEN_NUMBER  = 3'd1;
   localparam logic [WORD_W-1:0] TOKEN_HOUR    = 3'd2;
   localparam logic [WORD_W-1:0] TOKEN_HOURS   = 3'd3;
   localparam logic [WORD_W-1:0] TOKEN_MINUTE  = 3'd4;
   localparam logic [WORD_W-1:0] TOKEN_MINUTES = 3'd5;

   // Word slots of one say-time announcement, in speaking order.
   localparam logic [SLOT_W-1:0] SLOT_ITIS        = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_HOUR_NUM    = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_HOUR_WORD   = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_MINUTE_NUM  = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_MINUTE_WORD = 3'd4;

   typedef enum logic [1:0] {
      CMD_SAY,
      CMD_DONE,
      CMD_OTHER
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [HOUR_W-1:0]     hour;
      logic [MINUTE_W-1:0]   minute;
   } cmd_type;

   typedef struct packed {
      logic [WORD_W-1:0]   word;
      logic [NUMBER_W-1:0] number;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Build the ring buffer entry for one slot of an announcement.
   function automatic entry_type word_entry(input logic [SLOT_W-1:0]   slot,
                                            input logic [HOUR_W-1:0]   hour,
                                            input logic [MINUTE_W-1:0] minute);
      entry_type e;
      e.word   = TOKEN_ITIS;
      e.number = '0;
      unique case (slot)
         SLOT_ITIS: begin
            e.word = TOKEN_ITIS;
         end
         SLOT_HOUR_NUM: begin
            e.word   = TOKEN_NUMBER;
            e.number = NUMBER_W'(hour);
         end
         SLOT_HOUR_WORD: begin
            e.word = (hour == HOUR_W'(1)) ? TOKEN_HOUR : TOKEN_HOURS;
         end
         SLOT_MINUTE_NUM: begin
            e.word   = TOKEN_NUMBER;
            e.number = minute;
         end
         SLOT_MINUTE_WORD: begin
            e.word = (minute == MINUTE_W'(1)) ? TOKEN_MINUTE : TOKEN_MINUTES;
         end
         default: begin
            e.word   = TOKEN_ITIS;
            e.number = '0;
         end
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/spoken_time_word_queue.sv =====
// ============================================================================
// spoken_time_word_queue : word sequencer for a talking clock
// Queues the words of a time announcement in a ring buffer and issues a play
// request for the head word whenever the speaker is free.
// ============================================================================
//
//  channel  direction  payload
//  -------  ---------  ---------------------------------------------------------
//  req_     in         tuser: func[1:0]; tdata: hour[4:0], minute[10:5]
//  rsp_     out        tuser: recognized[0], play_start[1];
//                      tdata: play_word[2:0], play_number[8:3], words_dropped[11:9]
//
//  A say-time request passes the sequencer's write state (one word written per
//  cycle through the single ring write port); any other request skips it.
//  The intake queue holds two requests, so intake continues while the
//  sequencer works or a response waits for rsp_tready.
//  Reset is synchronous and clears pointers and speaking state; ring
//  contents are not cleared and are never read before being written.
//  One response is returned per request, in request order.
//
`default_nettype none

module spoken_time_word_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // hour[4:0], minute[10:5], zero padding above
   input  wire logic [stwq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // func[1:0]
   input  wire logic [stwq_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // play_word[2:0], play_number[8:3], words_dropped[11:9], zero padding above
   output logic      [stwq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // recognized[0], play_start[1]
   output logic      [stwq_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);
   import stwq_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   // Intake and command queue
   stwq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // Word sequencer and ring buffer
   stwq_back #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== rtl/core/stwq_ram.sv =====
// ============================================================================
// stwq_ram : generic simple dual-port RAM
// One write port and one read port with registered read data; the read data
// holds while no read is issued.
// ============================================================================
`default_nettype none

module stwq_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/stwq_front.sv =====
// ============================================================================
// stwq_front : request intake and command queue
// Classifies each request by its function code and holds up to two commands
// for the word sequencer, so intake goes on while the sequencer is busy.
// ============================================================================
`default_nettype none

module stwq_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [stwq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic [stwq_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                                   cmd_valid,
   output stwq_pkg::cmd_type                      cmd,
   input  wire logic                              cmd_pop
);
   import stwq_pkg::*;

   localparam int QD = 2;
   localparam int QIDX_W = 1;
   localparam int QCNT_W = 2;

   cmd_type            slot_ff [QD];
   logic [QIDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [QIDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   cmd_type            req_cmd;
   logic               push;
   logic               pop;
   logic [FUNC_W-1:0]  func;

   // Classify the request
   assign func = req_tuser[FUNC_W-1:0];
   always_comb begin
      req_cmd.hour   = req_tdata[HOUR_W-1:0];
      req_cmd.minute = req_tdata[HOUR_W+MINUTE_W-1:HOUR_W];
      priority if (func == FUNC_SAY_TIME) begin
         req_cmd.kind = CMD_SAY;
      end else if (func == FUNC_PLAY_DONE) begin
         req_cmd.kind = CMD_DONE;
      end else begin
         req_cmd.kind = CMD_OTHER;
      end
   end

   assign req_tready = (count_ff != QCNT_W'(QD));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != '0);
   assign pop        = cmd_pop && cmd_valid;
   assign cmd        = slot_ff[rd_idx_ff];

   // Advance the queue pointers
   always_comb begin
      wr_idx_in = push ? wr_idx_ff + 1'b1 : wr_idx_ff;
      rd_idx_in = pop ? rd_idx_ff + 1'b1 : rd_idx_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_idx_ff] <= req_cmd;
      end
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   // Queue bookkeeping checks
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QD))
      else $error("command queue over capacity");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == QCNT_W'(QD)) |-> (wr_idx_ff == rd_idx_ff))
      else $error("command queue full with pointers apart");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("command queue count missed a transfer");

endmodule

`default_nettype wire

// ===== rtl/core/stwq_back.sv =====
// ============================================================================
// stwq_back : word sequencer and ring buffer
// Executes one command at a time: writes the words of an announcement one per
// cycle into the ring buffer, retires the head word on finished-play while
// speaking, starts the next word when idle and loads the response register.
// ============================================================================
`default_nettype none

module stwq_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              cmd_valid,
   input  wire stwq_pkg::cmd_type                 cmd,
   output logic                                   cmd_pop,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [stwq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic      [stwq_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);
   import stwq_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRITE,
      ST_CHECK,
      ST_LOAD
   } state_type;

   state_type             state_ff, state_in;
   logic [HOUR_W-1:0]     hour_ff, hour_in;
   logic [MINUTE_W-1:0]   minute_ff, minute_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [DROPPED_W-1:0]  dropped_ff, dropped_in;
   logic                  recog_ff, recog_in;
   logic                  start_ff, start_in;
   logic [PTR_W-1:0]      wp_ff, wp_in;
   logic [PTR_W-1:0]      rp_ff, rp_in;
   logic                  speaking_ff, speaking_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_recog_ff, rsp_recog_in;
   logic                  rsp_start_ff, rsp_start_in;
   logic [WORD_W-1:0]     rsp_word_ff, rsp_word_in;
   logic [NUMBER_W-1:0]   rsp_number_ff, rsp_number_in;
   logic [DROPPED_W-1:0]  rsp_dropped_ff, rsp_dropped_in;

   logic [PTR_W-1:0]      wp_next;
   logic [PTR_W-1:0]      rp_next;
   entry_type             wr_entry;
   entry_type             rd_entry;
   logic [ENTRY_W-1:0]    ram_rd_data;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic                  out_free;

   assign wp_next  = (wp_ff == PTR_LAST) ? '0 : wp_ff + PTR_W'(1);
   assign rp_next  = (rp_ff == PTR_LAST) ? '0 : rp_ff + PTR_W'(1);
   assign wr_entry = word_entry(slot_ff, hour_ff, minute_ff);
   assign rd_entry = entry_type'(ram_rd_data);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Ring buffer of words
   stwq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH),
      .ADDR_W(PTR_W)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(wp_ff),
      .wr_data(wr_entry),
      .rd_en  (ram_rd_en),
      .rd_addr(rp_ff),
      .rd_data(ram_rd_data)
   );

   // Sequence one command
   always_comb begin
      state_in       = state_ff;
      hour_in        = hour_ff;
      minute_in      = minute_ff;
      slot_in        = slot_ff;
      dropped_in     = dropped_ff;
      recog_in       = recog_ff;
      start_in       = start_ff;
      wp_in          = wp_ff;
      rp_in          = rp_ff;
      speaking_in    = speaking_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_recog_in   = rsp_recog_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_number_in  = rsp_number_ff;
      rsp_dropped_in = rsp_dropped_ff;
      cmd_pop        = 1'b0;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop    = 1'b1;
               hour_in    = cmd.hour;
               minute_in  = cmd.minute;
               slot_in    = SLOT_ITIS;
               dropped_in = '0;
               recog_in   = (cmd.kind != CMD_OTHER);
               state_in   = ST_CHECK;
               if (cmd.kind == CMD_SAY) begin
                  state_in = ST_WRITE;
               end
               // Retire the head word only while speaking
               if (cmd.kind == CMD_DONE && speaking_ff) begin
                  rp_in       = rp_next;
                  speaking_in = 1'b0;
               end
            end
         end
         ST_WRITE: begin
            // Drop the word when the ring is full (one entry always stays empty)
            if (wp_next == rp_ff) begin
               dropped_in = dropped_ff + DROPPED_W'(1);
            end else begin
               ram_wr_en = 1'b1;
               wp_in     = wp_next;
            end
            slot_in = slot_ff + SLOT_W'(1);
            if (slot_ff == SLOT_MINUTE_WORD) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // Start the head word when idle and words wait
            start_in = 1'b0;
            if (!speaking_ff && (wp_ff != rp_ff)) begin
               ram_rd_en   = 1'b1;
               speaking_in = 1'b1;
               start_in    = 1'b1;
            end
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_recog_in   = recog_ff;
               rsp_start_in   = start_ff;
               rsp_word_in    = start_ff ? rd_entry.word : '0;
               rsp_number_in  = start_ff ? rd_entry.number : '0;
               rsp_dropped_in = dropped_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      hour_ff        <= hour_in;
      minute_ff      <= minute_in;
      slot_ff        <= slot_in;
      dropped_ff     <= dropped_in;
      recog_ff       <= recog_in;
      start_ff       <= start_in;
      rsp_recog_ff   <= rsp_recog_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_word_ff    <= rsp_word_in;
      rsp_number_ff  <= rsp_number_in;
      rsp_dropped_ff <= rsp_dropped_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         speaking_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         speaking_ff  <= speaking_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_dropped_ff, rsp_number_ff, rsp_word_ff});
   assign rsp_tuser  = RSP_TUSER_W'({rsp_start_ff, rsp_recog_ff});

   // Sequencer invariants
   assert property (@(posedge clock) disable iff (reset)
      (wp_ff <= PTR_LAST) && (rp_ff <= PTR_LAST))
      else $error("ring pointer beyond the last entry");

   assert property (@(posedge clock) disable iff (reset)
      speaking_ff |-> (wp_ff != rp_ff))
      else $error("speaking with an empty ring");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (speaking_ff || (wp_ff == rp_ff)))
      else $error("idle between commands with words waiting");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_start_ff) |-> rsp_recog_ff)
      else $error("word started by an unrecognised command");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_dropped_ff <= DROPPED_W'(5)))
      else $error("more words dropped than one announcement holds");

endmodule

`default_nettype wire

// ===== tb/sv/tb_spoken_time_word_queue.sv =====
// ============================================================================
// tb_spoken_time_word_queue : self-checking bench for the spoken time word queue
// Drives say-time, finished-play and unknown requests over the req_ stream,
// predicts every rsp_ transfer with a local copy of the word ring, and checks
// each response field by field. A short directed table comes first, then
// random traffic with random gaps on both sides, a long receiver hold-off
// and one drain pause of the sender.
// ============================================================================

module tb_spoken_time_word_queue;

   import stwq_pkg::*;

   localparam int QDEPTH          = 16;
   localparam int RANDOM_ITEMS    = 525;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AT     = 150;
   localparam int DRAIN_PAUSE_AT  = 300;
   localparam int SETTLE_CYCLES   = 40;

   // Function codes the block does not recognise
   localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_LO = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_HI = 2'd3;

   typedef struct packed {
      logic                 recognized;
      logic                 play_start;
      logic [WORD_W-1:0]    play_word;
      logic [NUMBER_W-1:0]  play_number;
      logic [DROPPED_W-1:0] words_dropped;
   } play_report_type;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic                typed;
      play_report_type     report;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // hour[4:0], minute[10:5]
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;   // func[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // play_word[2:0], play_number[8:3], words_dropped[11:9]
   logic [RSP_TUSER_W-1:0] rsp_tuser;  // recognized[0], play_start[1]

   // Local copy of the word ring
   logic [WORD_W-1:0]   ring_word   [QDEPTH];
   logic [NUMBER_W-1:0] ring_number [QDEPTH];
   int                  wr_ptr      = 0;
   int                  rd_ptr      = 0;
   logic                talking     = 1'b0;

   play_report_type pending_reports[$];
   stim_row_type    directed_rows[$];
   int              fail_count = 0;

   spoken_time_word_queue #(
      .QUEUE_DEPTH (QDEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int next_slot(input int p);
      return (p == QDEPTH - 1) ? 0 : p + 1;
   endfunction

   // Write one word at the tail, or report it dropped when the ring is full
   function automatic logic [DROPPED_W-1:0] store_word(input logic [WORD_W-1:0]   word,
                                                       input logic [NUMBER_W-1:0] number);
      if (next_slot(wr_ptr) == rd_ptr) begin
         return DROPPED_W'(1);
      end
      ring_word[wr_ptr]   = word;
      ring_number[wr_ptr] = number;
      wr_ptr              = next_slot(wr_ptr);
      return '0;
   endfunction

   // Advance the word ring by one request and return the response it causes
   function automatic play_report_type word_queue_step(input logic [FUNC_W-1:0]   func,
                                                       input logic [HOUR_W-1:0]   hour,
                                                       input logic [MINUTE_W-1:0] minute);
      play_report_type rep;
      rep            = '0;
      rep.recognized = 1'b1;
      if (func == FUNC_SAY_TIME) begin
         // One statement per word keeps the enqueue order fixed
         rep.words_dropped += store_word(TOKEN_ITIS, '0);
         rep.words_dropped += store_word(TOKEN_NUMBER, NUMBER_W'(hour));
         rep.words_dropped += store_word((hour == HOUR_W'(1)) ? TOKEN_HOUR : TOKEN_HOURS, '0);
         rep.words_dropped += store_word(TOKEN_NUMBER, minute);
         rep.words_dropped += store_word((minute == MINUTE_W'(1)) ? TOKEN_MINUTE : TOKEN_MINUTES,
                                         '0);
      end else if (func == FUNC_PLAY_DONE) begin
         if (talking) begin
            rd_ptr  = next_slot(rd_ptr);
            talking = 1'b0;
         end
      end else begin
         rep.recognized = 1'b0;
      end
      // Start the head word whenever the speaker is free
      if (!talking && wr_ptr != rd_ptr) begin
         talking         = 1'b1;
         rep.play_start  = 1'b1;
         rep.play_word   = ring_word[rd_ptr];
         rep.play_number = ring_number[rd_ptr];
      end
      return rep;
   endfunction

   function automatic void add_row(input logic [FUNC_W-1:0]    func,
                                   input logic [HOUR_W-1:0]    hour,
                                   input logic [MINUTE_W-1:0]  minute,
                                   input logic                 typed,
                                   input logic                 recognized,
                                   input logic                 play_start,
                                   input logic [WORD_W-1:0]    play_word,
                                   input logic [NUMBER_W-1:0]  play_number,
                                   input logic [DROPPED_W-1:0] words_dropped);
      stim_row_type row;
      row.func                 = func;
      row.hour                 = hour;
      row.minute               = minute;
      row.typed                = typed;
      row.report.recognized    = recognized;
      row.report.play_start    = play_start;
      row.report.play_word     = play_word;
      row.report.play_number   = play_number;
      row.report.words_dropped = words_dropped;
      directed_rows.push_back(row);
   endfunction

   // Offer one request after a gap; on the transfer, record what it must cause
   task automatic offer_request(input logic [FUNC_W-1:0]   func,
                                input logic [HOUR_W-1:0]   hour,
                                input logic [MINUTE_W-1:0] minute,
                                input logic                typed,
                                input play_report_type     typed_rep,
                                input int                  gap);
      play_report_type predicted;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= REQ_TDATA_W'({minute, hour});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = word_queue_step(func, hour, minute);
      pending_reports.push_back(typed ? typed_rep : predicted);
   endtask

   // Request side: reset, directed table, then random traffic
   initial begin : req_side
      stim_row_type        row;
      logic [FUNC_W-1:0]   func;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      int                  idx;
      int                  pick;
      int                  gap;

      // Power-up, unknown codes and a finished-play while idle
      add_row(FUNC_PLAY_DONE,  5'd0,  6'd0,  1'b1, 1'b1, 1'b0, '0, '0, '0);
      add_row(FUNC_UNKNOWN_LO, 5'd31, 6'd63, 1'b1, 1'b0, 1'b0, '0, '0, '0);
      add_row(FUNC_UNKNOWN_HI, 5'd0,  6'd0,  1'b1, 1'b0, 1'b0, '0, '0, '0);
      // Singular hour and minute; fill the ring to its last free entry
      add_row(FUNC_SAY_TIME,   5'd1,  6'd1,  1'b1, 1'b1, 1'b1, TOKEN_ITIS, '0, '0);
      add_row(FUNC_SAY_TIME,   5'd0,  6'd0,  1'b1, 1'b1, 1'b0, '0, '0, '0);
      add_row(FUNC_SAY_TIME,   5'd23, 6'd59, 1'b1, 1'b1, 1'b0, '0, '0, '0);
      // Full ring with out-of-range values: every word lost
      add_row(FUNC_SAY_TIME,   5'd31, 6'd63, 1'b1, 1'b1, 1'b0, '0, '0, DROPPED_W'(5));
      repeat (5) add_row(FUNC_PLAY_DONE, 5'd31, 6'd63, 1'b0, '0, '0, '0, '0, '0);
      add_row(FUNC_UNKNOWN_LO, 5'd17, 6'd42, 1'b0, '0, '0, '0, '0, '0);
      // Partly full ring: one announcement just fits, the next is lost entirely
      add_row(FUNC_SAY_TIME,   5'd12, 6'd30, 1'b0, '0, '0, '0, '0, '0);
      add_row(FUNC_SAY_TIME,   5'd2,  6'd1,  1'b0, '0, '0, '0, '0, '0);
      repeat (8) add_row(FUNC_PLAY_DONE, 5'd0, 6'd0, 1'b0, '0, '0, '0, '0, '0);
      add_row(FUNC_UNKNOWN_HI, 5'd31, 6'd0,  1'b0, '0, '0, '0, '0, '0);
      add_row(FUNC_SAY_TIME,   5'd10, 6'd0,  1'b0, '0, '0, '0, '0, '0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         offer_request(row.func, row.hour, row.minute, row.typed, row.report,
                       $urandom_range(0, 10));
      end

      // Random traffic, mostly well-formed announce/finish cycles
      idx = 0;
      while (idx < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if ((idx % 120) < 4 || pick < 15) begin
            func = FUNC_SAY_TIME;
         end else if (pick < 87) begin
            func = FUNC_PLAY_DONE;
         end else begin
            func = ($urandom_range(0, 1) != 0) ? FUNC_UNKNOWN_HI : FUNC_UNKNOWN_LO;
         end
         case ($urandom_range(0, 9))
            0:       hour = HOUR_W'(1);
            1:       hour = HOUR_W'($urandom_range(0, 31));
            default: hour = HOUR_W'($urandom_range(0, 23));
         endcase
         case ($urandom_range(0, 9))
            0:       minute = MINUTE_W'(1);
            1:       minute = MINUTE_W'($urandom_range(0, 63));
            default: minute = MINUTE_W'($urandom_range(0, 59));
         endcase
         gap = (((idx / 40) % 4) == 3) ? 0 : $urandom_range(0, 10);
         // Drop valid and hold until every response is back
         if (idx == DRAIN_PAUSE_AT) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (pending_reports.size() != 0) @(posedge clock);
         end
         offer_request(func, hour, minute, 1'b0, '0, gap);
         idx++;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain, then let any stray response show up
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Response side: random ready gaps, one long hold-off, field checks
   initial begin : rsp_side
      play_report_type got;
      play_report_type want;
      int              seen;
      int              hold;

      seen = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (seen == HOLD_OFF_AT) begin
            hold = HOLD_OFF_CYCLES;
         end else if (((seen / 40) % 4) == 1) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 10);
         end
         repeat (hold) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         seen++;

         got.recognized    = rsp_tuser[0];
         got.play_start    = rsp_tuser[1];
         got.play_word     = rsp_tdata[2:0];
         got.play_number   = rsp_tdata[8:3];
         got.words_dropped = rsp_tdata[11:9];
         if (pending_reports.size() == 0) begin
            $error("response transfer with no request outstanding");
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            if (got.recognized !== want.recognized) begin
               $error("recognized: expected %0d, got %0d", want.recognized, got.recognized);
               fail_count++;
            end
            if (got.play_start !== want.play_start) begin
               $error("play_start: expected %0d, got %0d", want.play_start, got.play_start);
               fail_count++;
            end
            if (got.play_word !== want.play_word) begin
               $error("play_word: expected %0d, got %0d", want.play_word, got.play_word);
               fail_count++;
            end
            if (got.play_number !== want.play_number) begin
               $error("play_number: expected %0d, got %0d", want.play_number, got.play_number);
               fail_count++;
            end
            if (got.words_dropped !== want.words_dropped) begin
               $error("words_dropped: expected %0d, got %0d",
                      want.words_dropped, got.words_dropped);
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== spoken_time_word_queue.f =====
rtl/core/stwq_pkg.sv
rtl/core/stwq_ram.sv
rtl/core/stwq_front.sv
rtl/core/stwq_back.sv
rtl/core/spoken_time_word_queue.sv
tb/sv/tb_spoken_time_word_queue.sv
